@@ hw/rtl/wuls_pkg.sv @@
// Package for the Wu antialiased line stepper: line modes, back-end states,
// the decoded command and status structs, and fixed widths. No dependencies.
package wuls_pkg;

  localparam int COORD_BITS_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int ERR_BITS        = 16;
  localparam int COV_BITS        = 8;
  localparam logic [COV_BITS-1:0] COV_FULL = 8'hFF;

  typedef enum logic [2:0] {
    LM_IDLE  = 3'd0,
    LM_HORIZ = 3'd1,
    LM_VERT  = 3'd2,
    LM_DIAG  = 3'd3,
    LM_YMAJ  = 3'd4,
    LM_XMAJ  = 3'd5
  } line_mode_e;

  typedef enum logic [1:0] {
    BK_RUN  = 2'd0,
    BK_DIV  = 2'd1,
    BK_PAIR = 2'd2
  } bk_state_e;

  // Decoded command control bits handed from the front end to the back end.
  typedef struct packed {
    logic       is_step;
    line_mode_e mode;
    logic       step_left;
  } wuls_ctrl_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic dividing;
    logic pair_pending;
  } wuls_bk_status_t;

endpackage

@@ hw/rtl/wuls_if.sv @@
// Channel interfaces of the line stepper: command input and pixel output.
// Valid/ready handshake; no package dependency.
interface wuls_cmd_if #(
  parameter int CW = 10
) ();
  logic          valid;
  logic          ready;
  logic          command;
  logic [CW-1:0] start_x;
  logic [CW-1:0] start_y;
  logic [CW-1:0] end_x;
  logic [CW-1:0] end_y;

  modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface wuls_pix_if #(
  parameter int CW = 10
) ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] pix_x;
  logic [CW-1:0] pix_y;
  logic [7:0]    coverage;
  logic          exact;
  logic          last;

  modport source (output valid, pix_x, pix_y, coverage, exact, last, input ready);
  modport sink   (input valid, pix_x, pix_y, coverage, exact, last, output ready);
endinterface

@@ hw/rtl/wuls_front.sv @@
// Front end: accepts commands, orders the endpoints downward and classifies
// the line. Depends on wuls_pkg and wuls_cmd_if.
module wuls_front import wuls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  wuls_cmd_if.sink              cmd_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output wuls_ctrl_t            ctrl_o,
  output logic [COORD_BITS-1:0] x0_o,
  output logic [COORD_BITS-1:0] y0_o,
  output logic [COORD_BITS-1:0] x1_o,
  output logic [COORD_BITS-1:0] y1_o,
  output logic [COORD_BITS-1:0] major_o,
  output logic [COORD_BITS-1:0] minor_o
);

  logic                  swap;
  logic                  left;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  line_mode_e            mode;

  assign cmd_i.ready = !q_full_i;
  assign q_push_o    = cmd_i.valid && !q_full_i;

  assign swap = cmd_i.start_y > cmd_i.end_y;
  assign x0_o = swap ? cmd_i.end_x   : cmd_i.start_x;
  assign y0_o = swap ? cmd_i.end_y   : cmd_i.start_y;
  assign x1_o = swap ? cmd_i.start_x : cmd_i.end_x;
  assign y1_o = swap ? cmd_i.start_y : cmd_i.end_y;

  assign left = x1_o < x0_o;
  assign dx   = left ? (x0_o - x1_o) : (x1_o - x0_o);
  assign dy   = y1_o - y0_o;

  // The step count is the larger delta in every mode.
  assign major_o = (dy > dx) ? dy : dx;
  assign minor_o = (dy > dx) ? dx : dy;

  always_comb begin
    priority if (dx == '0 && dy == '0) begin
      mode = LM_IDLE;
    end else if (dy == '0) begin
      mode = LM_HORIZ;
    end else if (dx == '0) begin
      mode = LM_VERT;
    end else if (dx == dy) begin
      mode = LM_DIAG;
    end else if (dy > dx) begin
      mode = LM_YMAJ;
    end else begin
      mode = LM_XMAJ;
    end
  end

  assign ctrl_o.is_step   = cmd_i.command;
  assign ctrl_o.mode      = mode;
  assign ctrl_o.step_left = left;

endmodule

@@ hw/rtl/wuls_fifo.sv @@
// Small register queue between the front and back ends.
// Depends on nothing but its parameters.
module wuls_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          pop_i,
  output logic [DW-1:0] rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CNTW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hw/rtl/wuls_back.sv @@
// Back end: holds the line state, runs the bit-serial error-step divider and
// drives the pixel output register. Depends on wuls_pkg and wuls_pix_if.
module wuls_back import wuls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  wuls_ctrl_t            ctrl_i,
  input  logic [COORD_BITS-1:0] x0_i,
  input  logic [COORD_BITS-1:0] y0_i,
  input  logic [COORD_BITS-1:0] x1_i,
  input  logic [COORD_BITS-1:0] y1_i,
  input  logic [COORD_BITS-1:0] major_i,
  input  logic [COORD_BITS-1:0] minor_i,
  output wuls_bk_status_t       status_o,
  wuls_pix_if.source            pix_o
);

  localparam int CW   = COORD_BITS;
  localparam int CNTW = $clog2(ERR_BITS);

  function automatic logic [CW-1:0] move_x(input logic [CW-1:0] x, input logic left);
    return left ? (x - CW'(1)) : (x + CW'(1));
  endfunction

  bk_state_e             state_q, state_d;
  line_mode_e            mode_q, mode_d;
  logic                  left_q, left_d;
  logic [CW-1:0]         cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0]         fin_x_q, fin_x_d, fin_y_q, fin_y_d;
  logic [CW-1:0]         steps_q, steps_d;
  logic [ERR_BITS-1:0]   acc_q, acc_d, inc_q, inc_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [CW-1:0]         out_x_q, out_x_d, out_y_q, out_y_d;
  logic [COV_BITS-1:0]   out_cov_q, out_cov_d;
  logic                  out_exact_q, out_exact_d, out_last_q, out_last_d;
  logic [CW-1:0]         pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic [COV_BITS-1:0]   pend_cov_q, pend_cov_d;

  logic                  slot_free, pop;
  logic                  major_mode_q, major_start, pair_step;
  logic [ERR_BITS-1:0]   acc_sum;
  logic                  wrapped;
  logic [COV_BITS-1:0]   wgt;
  logic [CW-1:0]         mx_cur, y_inc, ym_x, ym_x2, xm_y, xm_y2;
  logic [CW:0]           rem_dbl;
  logic                  rem_ge;

  assign slot_free    = !out_valid_q || pix_o.ready;
  assign pop          = (state_q == BK_RUN) && !q_empty_i && slot_free;
  assign q_pop_o      = pop;
  assign major_mode_q = (mode_q == LM_YMAJ) || (mode_q == LM_XMAJ);
  assign major_start  = !ctrl_i.is_step &&
                        ((ctrl_i.mode == LM_YMAJ) || (ctrl_i.mode == LM_XMAJ));
  assign pair_step    = ctrl_i.is_step && major_mode_q && (steps_q != CW'(1));

  // Error accumulator; the minor axis advances when the sum wraps.
  assign acc_sum = acc_q + inc_q;
  assign wrapped = acc_sum <= acc_q;
  assign wgt     = acc_sum[ERR_BITS-1 -: COV_BITS];

  assign mx_cur = move_x(cur_x_q, left_q);
  assign y_inc  = cur_y_q + CW'(1);
  assign ym_x   = wrapped ? mx_cur : cur_x_q;
  assign ym_x2  = move_x(ym_x, left_q);
  assign xm_y   = wrapped ? y_inc : cur_y_q;
  assign xm_y2  = xm_y + CW'(1);

  // One quotient bit per cycle; the remainder stays below the divisor.
  assign rem_dbl = {rem_q, 1'b0};
  assign rem_ge  = rem_dbl >= {1'b0, steps_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_RUN: begin
        if (pop && major_start) begin
          state_d = BK_DIV;
        end else if (pop && pair_step) begin
          state_d = BK_PAIR;
        end
      end
      BK_DIV: begin
        if (cnt_q == CNTW'(ERR_BITS - 1)) begin
          state_d = BK_RUN;
        end
      end
      BK_PAIR: begin
        if (slot_free) begin
          state_d = BK_RUN;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    left_d      = left_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    fin_x_d     = fin_x_q;
    fin_y_d     = fin_y_q;
    steps_d     = steps_q;
    acc_d       = acc_q;
    inc_d       = inc_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    pend_x_d    = pend_x_q;
    pend_y_d    = pend_y_q;
    pend_cov_d  = pend_cov_q;
    out_valid_d = out_valid_q && !pix_o.ready;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_cov_d   = out_cov_q;
    out_exact_d = out_exact_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      BK_RUN: begin
        if (pop && !ctrl_i.is_step) begin
          mode_d      = ctrl_i.mode;
          left_d      = ctrl_i.step_left;
          cur_x_d     = x0_i;
          cur_y_d     = y0_i;
          fin_x_d     = x1_i;
          fin_y_d     = y1_i;
          steps_d     = major_i;
          acc_d       = '0;
          inc_d       = '0;
          rem_d       = minor_i;
          cnt_d       = '0;
          out_valid_d = 1'b1;
          out_x_d     = x0_i;
          out_y_d     = y0_i;
          out_cov_d   = COV_FULL;
          out_exact_d = 1'b1;
          out_last_d  = ctrl_i.mode == LM_IDLE;
        end else if (pop) begin
          unique case (mode_q)
            LM_IDLE: begin
              mode_d = LM_IDLE;
            end
            LM_HORIZ, LM_VERT, LM_DIAG: begin
              if (mode_q != LM_VERT) begin
                cur_x_d = mx_cur;
                out_x_d = mx_cur;
              end else begin
                out_x_d = cur_x_q;
              end
              if (mode_q != LM_HORIZ) begin
                cur_y_d = y_inc;
                out_y_d = y_inc;
              end else begin
                out_y_d = cur_y_q;
              end
              steps_d     = steps_q - CW'(1);
              out_valid_d = 1'b1;
              out_cov_d   = COV_FULL;
              out_exact_d = 1'b1;
              out_last_d  = steps_q == CW'(1);
              if (steps_q == CW'(1)) begin
                mode_d = LM_IDLE;
              end
            end
            LM_YMAJ, LM_XMAJ: begin
              out_valid_d = 1'b1;
              if (steps_q == CW'(1)) begin
                // Final step of a major line: the endpoint alone.
                cur_x_d     = fin_x_q;
                cur_y_d     = fin_y_q;
                steps_d     = '0;
                mode_d      = LM_IDLE;
                out_x_d     = fin_x_q;
                out_y_d     = fin_y_q;
                out_cov_d   = COV_FULL;
                out_exact_d = 1'b1;
                out_last_d  = 1'b1;
              end else begin
                acc_d       = acc_sum;
                steps_d     = steps_q - CW'(1);
                out_cov_d   = ~wgt;
                out_exact_d = 1'b0;
                out_last_d  = 1'b0;
                pend_cov_d  = wgt;
                if (mode_q == LM_YMAJ) begin
                  cur_x_d  = ym_x;
                  cur_y_d  = y_inc;
                  out_x_d  = ym_x;
                  out_y_d  = y_inc;
                  pend_x_d = ym_x2;
                  pend_y_d = y_inc;
                end else begin
                  cur_x_d  = mx_cur;
                  cur_y_d  = xm_y;
                  out_x_d  = mx_cur;
                  out_y_d  = xm_y;
                  pend_x_d = mx_cur;
                  pend_y_d = xm_y2;
                end
              end
            end
            default: begin
              mode_d  = LM_IDLE;
              steps_d = '0;
            end
          endcase
        end
      end
      BK_DIV: begin
        rem_d = rem_ge ? CW'(rem_dbl - {1'b0, steps_q}) : rem_dbl[CW-1:0];
        inc_d = {inc_q[ERR_BITS-2:0], rem_ge};
        cnt_d = cnt_q + CNTW'(1);
      end
      BK_PAIR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_x_d     = pend_x_q;
          out_y_d     = pend_y_q;
          out_cov_d   = pend_cov_q;
          out_exact_d = 1'b0;
          out_last_d  = 1'b0;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !pix_o.ready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      mode_q      <= LM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q      <= left_d;
    cur_x_q     <= cur_x_d;
    cur_y_q     <= cur_y_d;
    fin_x_q     <= fin_x_d;
    fin_y_q     <= fin_y_d;
    steps_q     <= steps_d;
    acc_q       <= acc_d;
    inc_q       <= inc_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    pend_x_q    <= pend_x_d;
    pend_y_q    <= pend_y_d;
    pend_cov_q  <= pend_cov_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_cov_q   <= out_cov_d;
    out_exact_q <= out_exact_d;
    out_last_q  <= out_last_d;
  end

  assign pix_o.valid    = out_valid_q;
  assign pix_o.pix_x    = out_x_q;
  assign pix_o.pix_y    = out_y_q;
  assign pix_o.coverage = out_cov_q;
  assign pix_o.exact    = out_exact_q;
  assign pix_o.last     = out_last_q;

  assign status_o.dividing     = state_q == BK_DIV;
  assign status_o.pair_pending = state_q == BK_PAIR;

endmodule

@@ hw/rtl/wu_antialiased_line_stepper_core.sv @@
// Wu antialiased line stepper, top level. An accepted command is written into the
// queue, popped when the back end is free and registered in its output register.
// Throughput: one command per cycle into the queue while it is not full; the back
// end takes no new command while its output is stalled, it sends the second pixel
// of a pair, or the bit-serial error-step divider runs for a Y- or X-major start.
// Reset (rst_ni, async, active low) empties the queue and output and idles the line.
module wu_antialiased_line_stepper_core import wuls_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wuls_cmd_if.sink    cmd_i,
  wuls_pix_if.source  pix_o
);

  // A queue entry is the decoded control word followed by the ordered
  // endpoints and the major and minor deltas.
  localparam int CTW = $bits(wuls_ctrl_t);
  localparam int QW  = CTW + 6 * COORD_BITS;

  wuls_ctrl_t            f_ctrl;
  logic [COORD_BITS-1:0] f_x0, f_y0, f_x1, f_y1, f_major, f_minor;
  logic                  q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]         q_wdata, q_rdata;

  wuls_ctrl_t            b_ctrl;
  logic [COORD_BITS-1:0] b_x0, b_y0, b_x1, b_y1, b_major, b_minor;
  wuls_bk_status_t       bk_status;

  // The front end classifies each command as it is accepted, so the back end
  // never waits on the compare and subtract chain.
  wuls_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .ctrl_o   (f_ctrl),
    .x0_o     (f_x0),
    .y0_o     (f_y0),
    .x1_o     (f_x1),
    .y1_o     (f_y1),
    .major_o  (f_major),
    .minor_o  (f_minor)
  );

  assign q_wdata = {f_ctrl, f_x0, f_y0, f_x1, f_y1, f_major, f_minor};

  // The queue lets commands keep arriving while the back end divides or
  // waits for the pixel writer.
  wuls_fifo #(
    .DW    (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_ctrl, b_x0, b_y0, b_x1, b_y1, b_major, b_minor} = q_rdata;

  // The back end owns the line state and the output register; a pixel pair
  // leaves over two transfers.
  wuls_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .ctrl_i    (b_ctrl),
    .x0_i      (b_x0),
    .y0_i      (b_y0),
    .x1_i      (b_x1),
    .y1_i      (b_y1),
    .major_i   (b_major),
    .minor_i   (b_minor),
    .status_o  (bk_status),
    .pix_o     (pix_o)
  );

  // The back end must never take an entry from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // No new command may be taken while the divider or a pending pair is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_status.dividing || bk_status.pair_pending) |-> !q_pop)
    else $error("command taken while back end busy");

  // Pixels of a pair are never the final pixel of a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && !pix_o.exact) |-> !pix_o.last)
    else $error("weighted pixel flagged as last");

  // Exact pixels always carry full coverage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.exact) |-> (pix_o.coverage == COV_FULL))
    else $error("exact pixel without full coverage");

endmodule

@@ tb/tb_wu_antialiased_line_stepper_core.sv @@
// Self-checking testbench for the Wu antialiased line stepper core.
// It drives line commands and checks every pixel against a predictor of its own.
// Depends on wuls_pkg, the wuls_cmd_if/wuls_pix_if interfaces and the core.
`timescale 1ns / 1ps

module tb_wu_antialiased_line_stepper_core;
  import wuls_pkg::*;

  localparam int COORD_BITS = COORD_BITS_DEF;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  // Command codes carried in the command field of a transfer.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [COV_BITS-1:0]   cov_t;

  typedef struct packed {
    logic   command;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    cov_t   coverage;
    logic   exact;
    logic   last;
  } pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  wuls_cmd_if #(.CW(COORD_BITS)) cmd_bus ();
  wuls_pix_if #(.CW(COORD_BITS)) pix_bus ();

  // Every channel input of the block is driven from these variables, so all of them
  // hold a known value from time zero on.
  logic      cmd_valid = 1'b0;
  line_cmd_t cmd_word  = '0;
  logic      pix_ready = 1'b0;

  assign cmd_bus.valid   = cmd_valid;
  assign cmd_bus.command = cmd_word.command;
  assign cmd_bus.start_x = cmd_word.start_x;
  assign cmd_bus.start_y = cmd_word.start_y;
  assign cmd_bus.end_x   = cmd_word.end_x;
  assign cmd_bus.end_y   = cmd_word.end_y;
  assign pix_bus.ready   = pix_ready;

  wu_antialiased_line_stepper_core #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .pix_o (pix_bus)
  );

  // Commands waiting to be transferred; the head is the one on the bus.
  line_cmd_t cmd_backlog[$];
  // Pixels the block still owes, oldest first.
  pixel_t    pixels_due[$];

  // Idle percentages of the sender and the receiver for the current phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  logic cmd_taken = 1'b0;
  int   mismatch_count = 0;
  int   cmds_queued = 0;

  // Shadow copy of the line state, advanced once per accepted command.
  coord_t     ln_cur_x   = '0;
  coord_t     ln_cur_y   = '0;
  coord_t     ln_end_x   = '0;
  coord_t     ln_end_y   = '0;
  logic       ln_left    = 1'b0;
  coord_t     ln_steps   = '0;
  err_t       ln_acc     = '0;
  err_t       ln_inc     = '0;
  line_mode_e ln_mode    = LM_IDLE;

  // One column toward the line's end, wrapping at the coordinate width.
  function automatic coord_t toward_end(coord_t x);
    return ln_left ? coord_t'(x - 1'b1) : coord_t'(x + 1'b1);
  endfunction

  function automatic void owe_pixel(coord_t x, coord_t y, cov_t cov, logic exact,
                                    logic last);
    pixel_t p;
    p.x        = x;
    p.y        = y;
    p.coverage = cov;
    p.exact    = exact;
    p.last     = last;
    pixels_due.push_back(p);
  endfunction

  // Advances the shadow line state by one accepted command and records the
  // pixels that the command must produce.
  function automatic void trace_line_cmd(line_cmd_t c);
    coord_t x0, y0, x1, y1, dx, dy, major, minor, swap;
    logic [COORD_BITS+ERR_BITS-1:0] scaled;
    err_t   prev_acc;
    logic   wrapped;
    logic   final_px;
    cov_t   w;

    if (c.command == CMD_START) begin
      x0 = c.start_x;
      y0 = c.start_y;
      x1 = c.end_x;
      y1 = c.end_y;
      // The line always runs toward increasing rows.
      if (y0 > y1) begin
        swap = y0; y0 = y1; y1 = swap;
        swap = x0; x0 = x1; x1 = swap;
      end
      ln_cur_x = x0;
      ln_cur_y = y0;
      ln_end_x = x1;
      ln_end_y = y1;
      ln_left  = (x1 < x0);
      dx       = ln_left ? coord_t'(x0 - x1) : coord_t'(x1 - x0);
      dy       = coord_t'(y1 - y0);
      ln_acc   = '0;
      ln_inc   = '0;
      if (dx == 0 && dy == 0) begin
        // A single point is complete at once.
        ln_mode  = LM_IDLE;
        ln_steps = '0;
        owe_pixel(x0, y0, COV_FULL, 1'b1, 1'b1);
        return;
      end
      owe_pixel(x0, y0, COV_FULL, 1'b1, 1'b0);
      if (dy == 0) begin
        ln_mode  = LM_HORIZ;
        ln_steps = dx;
      end else if (dx == 0) begin
        ln_mode  = LM_VERT;
        ln_steps = dy;
      end else if (dx == dy) begin
        ln_mode  = LM_DIAG;
        ln_steps = dy;
      end else begin
        if (dy > dx) begin
          ln_mode = LM_YMAJ;
          major   = dy;
          minor   = dx;
        end else begin
          ln_mode = LM_XMAJ;
          major   = dx;
          minor   = dy;
        end
        // Fractional minor advance per major step, 16 bits after the point.
        scaled   = {minor, {ERR_BITS{1'b0}}};
        ln_inc   = err_t'(scaled / major);
        ln_steps = major;
      end
      return;
    end

    // A step with no line in progress produces nothing.
    if (ln_mode == LM_IDLE || ln_steps == 0) begin
      ln_mode = LM_IDLE;
      return;
    end

    if (ln_mode == LM_HORIZ || ln_mode == LM_VERT || ln_mode == LM_DIAG) begin
      if (ln_mode != LM_VERT) ln_cur_x = toward_end(ln_cur_x);
      if (ln_mode != LM_HORIZ) ln_cur_y = coord_t'(ln_cur_y + 1'b1);
      ln_steps = coord_t'(ln_steps - 1'b1);
      final_px = (ln_steps == 0);
      if (final_px) ln_mode = LM_IDLE;
      owe_pixel(ln_cur_x, ln_cur_y, COV_FULL, 1'b1, final_px);
      return;
    end

    // In the major modes the last step lands exactly on the endpoint.
    if (ln_steps == 1) begin
      ln_cur_x = ln_end_x;
      ln_cur_y = ln_end_y;
      ln_steps = '0;
      ln_mode  = LM_IDLE;
      owe_pixel(ln_end_x, ln_end_y, COV_FULL, 1'b1, 1'b1);
      return;
    end

    // Otherwise a pixel pair straddles the ideal line; the minor coordinate
    // moves whenever the accumulator wraps.
    prev_acc = ln_acc;
    ln_acc   = err_t'(ln_acc + ln_inc);
    wrapped  = (ln_acc <= prev_acc);
    w        = ln_acc[ERR_BITS-1 -: COV_BITS];
    ln_steps = coord_t'(ln_steps - 1'b1);
    if (ln_mode == LM_YMAJ) begin
      if (wrapped) ln_cur_x = toward_end(ln_cur_x);
      ln_cur_y = coord_t'(ln_cur_y + 1'b1);
      owe_pixel(ln_cur_x, ln_cur_y, cov_t'(COV_FULL - w), 1'b0, 1'b0);
      owe_pixel(toward_end(ln_cur_x), ln_cur_y, w, 1'b0, 1'b0);
    end else begin
      if (wrapped) ln_cur_y = coord_t'(ln_cur_y + 1'b1);
      ln_cur_x = toward_end(ln_cur_x);
      owe_pixel(ln_cur_x, ln_cur_y, cov_t'(COV_FULL - w), 1'b0, 1'b0);
      owe_pixel(ln_cur_x, coord_t'(ln_cur_y + 1'b1), w, 1'b0, 1'b0);
    end
  endfunction

  // Driver: inputs change on the falling edge. A command stays on the bus
  // until it is transferred; only then may a gap or the next command follow.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!cmd_valid || cmd_taken) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_valid <= 1'b1;
          cmd_word  <= cmd_backlog[0];
        end else begin
          cmd_valid <= 1'b0;
        end
      end
      pix_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: on the rising edge, feed transferred commands to the predictor
  // and check every transferred pixel against the oldest one owed.
  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;

    cmd_taken = 1'b0;
    if (rst_ni) begin
      if (cmd_valid && cmd_bus.ready) begin
        cmd_taken = 1'b1;
        trace_line_cmd(cmd_word);
        void'(cmd_backlog.pop_front());
      end

      if (pix_bus.valid && pix_ready) begin
        got.x        = pix_bus.pix_x;
        got.y        = pix_bus.pix_y;
        got.coverage = pix_bus.coverage;
        got.exact    = pix_bus.exact;
        got.last     = pix_bus.last;
        if (pixels_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected pixel x=%0d y=%0d cov=%0d exact=%0b last=%0b",
                     $realtime, got.x, got.y, got.coverage, got.exact, got.last);
        end else begin
          want = pixels_due.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.coverage !== want.coverage ||
              got.exact !== want.exact || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: pixel mismatch expected x=%0d y=%0d cov=%0d exact=%0b last=%0b",
                       $realtime, want.x, want.y, want.coverage, want.exact, want.last);
              $display("    got x=%0d y=%0d cov=%0d exact=%0b last=%0b",
                       got.x, got.y, got.coverage, got.exact, got.last);
            end
          end
        end
      end
    end
  end

  task automatic queue_cmd(logic command, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    line_cmd_t c;
    c.command = command;
    c.start_x = sx;
    c.start_y = sy;
    c.end_x   = ex;
    c.end_y   = ey;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  task automatic queue_start(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    queue_cmd(CMD_START, sx, sy, ex, ey);
  endtask

  // Step commands carry random endpoint fields, which the block must ignore.
  task automatic queue_steps(int count);
    for (int i = 0; i < count; i++)
      queue_cmd(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom));
  endtask

  // One random line: mostly short lines walked to their end, sometimes one or two
  // extra steps past the end, sometimes cut short by the next start. Long lines only
  // get at most 30 steps before they are dropped, which keeps the run short.
  task automatic queue_random_line();
    int shape;
    int sx, sy, ex, ey, dx, dy, span, steps;

    shape = $urandom_range(99);
    sx = $urandom_range(COORD_MAX);
    sy = $urandom_range(COORD_MAX);
    if (shape < 20) begin
      ex = $urandom_range(COORD_MAX);
      ey = $urandom_range(COORD_MAX);
    end else begin
      dx = $urandom_range(12);
      dy = $urandom_range(12);
      if (shape < 35) dy = 0;
      else if (shape < 50) dy = dx;
      else if (shape < 60) dx = 0;
      ex = $urandom_range(1) ? sx + dx : sx - dx;
      ey = $urandom_range(1) ? sy + dy : sy - dy;
      if (ex < 0 || ex > COORD_MAX) ex = 2 * sx - ex;
      if (ey < 0 || ey > COORD_MAX) ey = 2 * sy - ey;
    end
    span = (ex > sx) ? ex - sx : sx - ex;
    if (((ey > sy) ? ey - sy : sy - ey) > span) span = (ey > sy) ? ey - sy : sy - ey;

    if (span > 40) steps = $urandom_range(30);
    else if ($urandom_range(9) == 0) steps = $urandom_range(span);
    else steps = span + (($urandom_range(7) == 0) ? $urandom_range(2, 1) : 0);

    queue_start(coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
    queue_steps(steps);
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || pixels_due.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus: directed lines first, then four phases of random lines under
  // different idle patterns on the two channels.
  initial begin
    int phase_end;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A step straight after reset must be ignored.
    queue_cmd(CMD_STEP, coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX));
    // Single points at both corners.
    queue_start('0, '0, '0, '0);
    queue_start(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
                coord_t'(COORD_MAX));
    // Horizontal line running left from the right edge.
    queue_start(coord_t'(COORD_MAX), 5, coord_t'(COORD_MAX - 2), 5);
    queue_steps(2);
    // Vertical line given bottom first, so the endpoints swap; one spare step.
    queue_start(7, coord_t'(COORD_MAX), 7, coord_t'(COORD_MAX - 2));
    queue_steps(3);
    // Diagonal running left.
    queue_start(2, 0, 0, 2);
    queue_steps(2);
    // Y-major line running left from the top right corner.
    queue_start(coord_t'(COORD_MAX), 0, coord_t'(COORD_MAX - 1), 3);
    queue_steps(3);
    // X-major line at the bottom edge.
    queue_start(0, coord_t'(COORD_MAX - 1), 3, coord_t'(COORD_MAX));
    queue_steps(3);
    // Full-screen diagonal, dropped by a new start after one step.
    queue_start('0, '0, coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    queue_steps(1);
    queue_start(coord_t'(COORD_MAX), coord_t'(COORD_MAX), 0, coord_t'(COORD_MAX - 1));
    queue_steps(1);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      phase_end = cmds_queued + 300;
      while (cmds_queued < phase_end) begin
        // A few lone commands of any kind as noise between the lines.
        if ($urandom_range(99) < 6)
          queue_cmd(1'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom));
        else
          queue_random_line();
      end
    end

    wait_drained();
    // Steps that produce nothing may still be in the block's queue.
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0 && pixels_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/wuls_pkg.sv
hw/rtl/wuls_if.sv
hw/rtl/wuls_front.sv
hw/rtl/wuls_fifo.sv
hw/rtl/wuls_back.sv
hw/rtl/wu_antialiased_line_stepper_core.sv
tb/tb_wu_antialiased_line_stepper_core.sv
